// ----- rtl/aep_pkg.sv -----
// ----------------------------------------------------------------------------
// aep_pkg
// Shared types, constants and helper functions of the escape sequence parser.
// ----------------------------------------------------------------------------
package aep_pkg;

    localparam int MAX_PARAMS  = 5;
    localparam int CNT_W       = $clog2(MAX_PARAMS + 2);
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int NUM_REGS  = 6;
    localparam int PADDR_W   = $clog2(4 * NUM_REGS);
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 32;

    localparam logic [REG_IDX_W-1:0] REG_NORMAL_ATTR  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_REVERSE_ATTR = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_BOLD_ATTR    = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_ROWS  = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_COLS  = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_SCROLL_LIMIT = REG_IDX_W'(5);

    localparam logic [7:0] RST_NORMAL_ATTR  = 8'd7;
    localparam logic [7:0] RST_REVERSE_ATTR = 8'd112;
    localparam logic [7:0] RST_BOLD_ATTR    = 8'd15;
    localparam logic [7:0] RST_SCREEN_ROWS  = 8'd24;
    localparam logic [7:0] RST_SCREEN_COLS  = 8'd80;
    localparam logic [7:0] RST_SCROLL_LIMIT = 8'd23;

    localparam logic [7:0] ESC_BYTE     = 8'd27;
    localparam logic [7:0] SAT_LIMIT    = 8'd255;
    localparam logic [7:0] CHR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHR_SEMI     = 8'h3B;
    localparam logic [7:0] CHR_ZERO     = 8'h30;

    localparam logic [7:0] CMD_CLEAR   = 8'h4A; // J
    localparam logic [7:0] CMD_ERASE   = 8'h4B; // K
    localparam logic [7:0] CMD_STATUS  = 8'h6E; // n
    localparam logic [7:0] CMD_SGR     = 8'h6D; // m
    localparam logic [7:0] CMD_SAVE    = 8'h73; // s
    localparam logic [7:0] CMD_RESTORE = 8'h75; // u
    localparam logic [7:0] CMD_UP      = 8'h41; // A
    localparam logic [7:0] CMD_DOWN    = 8'h42; // B
    localparam logic [7:0] CMD_RIGHT   = 8'h43; // C
    localparam logic [7:0] CMD_LEFT    = 8'h44; // D
    localparam logic [7:0] CMD_POS_F   = 8'h66; // f
    localparam logic [7:0] CMD_POS_H   = 8'h48; // H

    localparam logic [7:0] SGR_NORMAL    = 8'd0;
    localparam logic [7:0] SGR_BOLD      = 8'd1;
    localparam logic [7:0] SGR_UNDERLINE = 8'd4;
    localparam logic [7:0] SGR_BLINK     = 8'd5;
    localparam logic [7:0] SGR_REVERSE   = 8'd7;
    localparam logic [7:0] SGR_FG_LO     = 8'd30;
    localparam logic [7:0] SGR_FG_HI     = 8'd37;
    localparam logic [7:0] SGR_BG_LO     = 8'd40;
    localparam logic [7:0] SGR_BG_HI     = 8'd47;
    localparam logic [7:0] DSR_CURSOR    = 8'd6;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_CLEAR   = 3'd1,
        ACT_ERASE   = 3'd2,
        ACT_STATUS  = 3'd3,
        ACT_MOVE    = 3'd4,
        ACT_UNKNOWN = 3'd5
    } t_action;

    typedef struct packed {
        logic [7:0] normal_attr;
        logic [7:0] reverse_attr;
        logic [7:0] bold_attr;
        logic [7:0] screen_rows;
        logic [7:0] screen_cols;
        logic [7:0] scroll_limit;
    } t_cfg;

    typedef struct packed {
        logic                        in_seq;
        logic                        exec;
        logic [7:0]                  letter;
        logic [CNT_W-1:0]            argc;
        logic [MAX_PARAMS-1:0][7:0]  args;
        logic                        lead_semi;
        logic [7:0]                  row;
        logic [7:0]                  col;
    } t_cmd;

    typedef struct packed {
        logic [7:0] attr;
        logic       blink;
        logic       bold;
    } t_attr_state;

    typedef struct packed {
        logic       in_seq;
        t_action    action;
        logic [7:0] new_row;
        logic [7:0] new_col;
        logic [7:0] text_attr;
    } t_result;

    function automatic logic [2:0] colour_map(input logic [2:0] idx);
        logic [2:0] m;
        case (idx)
            3'd0:    m = 3'h0;
            3'd1:    m = 3'h4;
            3'd2:    m = 3'h2;
            3'd3:    m = 3'h6;
            3'd4:    m = 3'h1;
            3'd5:    m = 3'h5;
            3'd6:    m = 3'h3;
            default: m = 3'h7;
        endcase
        return m;
    endfunction

    function automatic t_attr_state apply_sgr(input t_attr_state s, input logic [7:0] v,
                                              input t_cfg cfg);
        t_attr_state r;
        logic [7:0]  off;
        r = s;
        off = 8'd0;
        case (v) inside
            SGR_BLINK: begin
                r.attr  = s.attr | 8'h80;
                r.blink = 1'b1;
            end
            SGR_UNDERLINE: begin
                r.attr = s.attr | 8'h01;
            end
            SGR_REVERSE: begin
                r.attr = cfg.reverse_attr;
            end
            SGR_NORMAL: begin
                r.attr  = cfg.normal_attr;
                r.blink = 1'b0;
                r.bold  = 1'b0;
            end
            SGR_BOLD: begin
                r.attr = cfg.bold_attr;
                r.bold = 1'b1;
            end
            [SGR_BG_LO:SGR_BG_HI]: begin
                off    = v - SGR_BG_LO;
                r.attr = {s.blink, colour_map(off[2:0]), s.attr[3:0]};
            end
            [SGR_FG_LO:SGR_FG_HI]: begin
                off    = v - SGR_FG_LO;
                r.attr = {s.attr[7:4], s.bold, colour_map(off[2:0])};
            end
            default: begin
                r = s;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/ansi_escape_parser_top.sv -----
// ----------------------------------------------------------------------------
// ansi_escape_parser_top
// Terminal escape sequence parser: classifier, command queue, executor.
//
//  channel   direction  handshake                  payload
//  s (in)    slave      i_s_tvalid / o_s_tready    i_s_tdata  char, row, col
//  m (out)   master     o_m_tvalid / i_m_tready    o_m_tdata  seq, action, row, col, attr
//  apb       slave      psel, penable, pwrite      paddr, pwdata, prdata
//
//  one byte per cycle while the output accepts results; a result passes through
//  a queue slot and then the result register after its byte is accepted
//  reset is synchronous and active low
//  a stalled output fills the two-slot queue before input ready drops
// ----------------------------------------------------------------------------
module ansi_escape_parser_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [aep_pkg::IN_W-1:0]    i_s_tdata,  // char_in, cur_row, cur_col
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [aep_pkg::OUT_W-1:0]   o_m_tdata,  // in_sequence, action, new_row,
                                                    // new_col, text_attr, zero pad
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aep_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    aep_pkg::t_cfg    cfg;
    aep_pkg::t_cmd    push_cmd;
    aep_pkg::t_cmd    head_cmd;
    aep_pkg::t_result result;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;

    aep_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    aep_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_room  (!q_full),
        .i_char  (i_s_tdata[7:0]),
        .i_row   (i_s_tdata[15:8]),
        .i_col   (i_s_tdata[23:16]),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    aep_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    aep_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd      (head_cmd),
        .i_empty    (q_empty),
        .i_m_tready (i_m_tready),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .o_result   (result)
    );

    assign o_m_tdata = {4'd0, result.text_attr, result.new_col, result.new_row,
                        result.action, result.in_seq};

endmodule

// ----- rtl/aep_cfg.sv -----
// ----------------------------------------------------------------------------
// aep_cfg
// Configuration register bank behind the peripheral bus port.
// ----------------------------------------------------------------------------
module aep_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aep_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output aep_pkg::t_cfg               o_cfg
);

    aep_pkg::t_cfg                  r_cfg;
    logic [aep_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                           wr_en;
    logic [7:0]                     rd_val;

    assign reg_idx = paddr[aep_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_attr  <= aep_pkg::RST_NORMAL_ATTR;
            r_cfg.reverse_attr <= aep_pkg::RST_REVERSE_ATTR;
            r_cfg.bold_attr    <= aep_pkg::RST_BOLD_ATTR;
            r_cfg.screen_rows  <= aep_pkg::RST_SCREEN_ROWS;
            r_cfg.screen_cols  <= aep_pkg::RST_SCREEN_COLS;
            r_cfg.scroll_limit <= aep_pkg::RST_SCROLL_LIMIT;
        end else if (wr_en) begin
            case (reg_idx)
                aep_pkg::REG_NORMAL_ATTR:  r_cfg.normal_attr  <= pwdata[7:0];
                aep_pkg::REG_REVERSE_ATTR: r_cfg.reverse_attr <= pwdata[7:0];
                aep_pkg::REG_BOLD_ATTR:    r_cfg.bold_attr    <= pwdata[7:0];
                aep_pkg::REG_SCREEN_ROWS:  r_cfg.screen_rows  <= pwdata[7:0];
                aep_pkg::REG_SCREEN_COLS:  r_cfg.screen_cols  <= pwdata[7:0];
                aep_pkg::REG_SCROLL_LIMIT: r_cfg.scroll_limit <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            aep_pkg::REG_NORMAL_ATTR:  rd_val = r_cfg.normal_attr;
            aep_pkg::REG_REVERSE_ATTR: rd_val = r_cfg.reverse_attr;
            aep_pkg::REG_BOLD_ATTR:    rd_val = r_cfg.bold_attr;
            aep_pkg::REG_SCREEN_ROWS:  rd_val = r_cfg.screen_rows;
            aep_pkg::REG_SCREEN_COLS:  rd_val = r_cfg.screen_cols;
            aep_pkg::REG_SCROLL_LIMIT: rd_val = r_cfg.scroll_limit;
            default:                   rd_val = 8'd0;
        endcase
    end

    assign prdata = {24'd0, rd_val};

endmodule

// ----- rtl/aep_front.sv -----
// ----------------------------------------------------------------------------
// aep_front
// Byte classifier: tracks escape state and collects decimal parameters,
// emitting one command descriptor per byte.
// ----------------------------------------------------------------------------
module aep_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_room,
    input  logic [7:0]    i_char,
    input  logic [7:0]    i_row,
    input  logic [7:0]    i_col,
    output logic          o_ready,
    output logic          o_push,
    output aep_pkg::t_cmd o_cmd
);

    localparam int MP = aep_pkg::MAX_PARAMS;
    localparam int CW = aep_pkg::CNT_W;

    logic                  r_esc_pend, n_esc_pend;
    logic [MP-1:0][7:0]    r_params,   n_params;
    logic [CW-1:0]         r_count,    n_count;
    logic                  r_digit,    n_digit;
    logic                  r_empty,    n_empty;
    logic                  r_lead,     n_lead;

    logic        is_letter;
    logic        is_digit;
    logic [7:0]  digit;
    logic [7:0]  cur_val;
    logic [11:0] acc;
    logic [7:0]  acc_sat;

    assign o_ready = i_room;
    assign o_push  = i_valid && i_room;

    always_comb begin
        is_letter = (i_char inside {[8'h41:8'h5A], [8'h61:8'h7A]});
        is_digit  = (i_char inside {[8'h30:8'h39]});
        digit     = i_char - aep_pkg::CHR_ZERO;

        cur_val = 8'd0;
        for (int i = 0; i < MP; i++) begin
            if (r_count == CW'(i + 1)) begin
                cur_val = r_params[i];
            end
        end
        acc     = {4'd0, cur_val} * 12'd10 + {4'd0, digit};
        acc_sat = (acc > {4'd0, aep_pkg::SAT_LIMIT}) ? aep_pkg::SAT_LIMIT : acc[7:0];

        n_esc_pend = r_esc_pend;
        n_params   = r_params;
        n_count    = r_count;
        n_digit    = r_digit;
        n_empty    = r_empty;
        n_lead     = r_lead;

        o_cmd.in_seq    = 1'b0;
        o_cmd.exec      = 1'b0;
        o_cmd.letter    = i_char;
        o_cmd.argc      = (r_count > CW'(MP)) ? CW'(MP) : r_count;
        o_cmd.args      = r_params;
        o_cmd.lead_semi = r_lead;
        o_cmd.row       = i_row;
        o_cmd.col       = i_col;

        if (i_char == aep_pkg::ESC_BYTE) begin
            n_params     = '0;
            n_count      = '0;
            n_digit      = 1'b0;
            n_empty      = 1'b1;
            n_lead       = 1'b0;
            n_esc_pend   = 1'b1;
            o_cmd.in_seq = 1'b1;
        end else if (r_esc_pend) begin
            n_esc_pend   = 1'b0;
            o_cmd.in_seq = (i_char == aep_pkg::CHR_LBRACKET);
        end else if (!is_letter) begin
            if (is_digit) begin
                if (r_digit) begin
                    for (int i = 0; i < MP; i++) begin
                        if (r_count == CW'(i + 1)) begin
                            n_params[i] = acc_sat;
                        end
                    end
                end else begin
                    if (r_count <= CW'(MP)) begin
                        n_count = r_count + CW'(1);
                        for (int i = 0; i < MP; i++) begin
                            if (r_count == CW'(i)) begin
                                n_params[i] = digit;
                            end
                        end
                    end
                    n_digit = 1'b1;
                end
            end else begin
                if (r_empty && i_char == aep_pkg::CHR_SEMI) begin
                    n_lead = 1'b1;
                end
                n_digit = 1'b0;
            end
            n_empty      = 1'b0;
            o_cmd.in_seq = 1'b1;
        end else begin
            o_cmd.exec = 1'b1;
            n_params   = '0;
            n_count    = '0;
            n_digit    = 1'b0;
            n_empty    = 1'b1;
            n_lead     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_pend <= 1'b0;
            r_params   <= '0;
            r_count    <= '0;
            r_digit    <= 1'b0;
            r_empty    <= 1'b1;
            r_lead     <= 1'b0;
        end else if (o_push) begin
            r_esc_pend <= n_esc_pend;
            r_params   <= n_params;
            r_count    <= n_count;
            r_digit    <= n_digit;
            r_empty    <= n_empty;
            r_lead     <= n_lead;
        end
    end

endmodule

// ----- rtl/aep_fifo.sv -----
// ----------------------------------------------------------------------------
// aep_fifo
// Short command queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module aep_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  aep_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output aep_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    localparam int DEPTH = aep_pkg::QUEUE_DEPTH;
    localparam int PW    = aep_pkg::PTR_W;
    localparam int QW    = aep_pkg::QCNT_W;

    aep_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [QW-1:0] r_count;

    assign o_full  = (r_count == QW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QW'(1);
            end
        end
    end

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

// ----- rtl/aep_back.sv -----
// ----------------------------------------------------------------------------
// aep_back
// Command executor: attribute and saved cursor state, cursor arithmetic,
// and the registered result stage.
// ----------------------------------------------------------------------------
module aep_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  aep_pkg::t_cfg    i_cfg,
    input  aep_pkg::t_cmd    i_cmd,
    input  logic             i_empty,
    input  logic             i_m_tready,
    output logic             o_pop,
    output logic             o_valid,
    output aep_pkg::t_result o_result
);

    localparam int MP = aep_pkg::MAX_PARAMS;
    localparam int CW = aep_pkg::CNT_W;

    aep_pkg::t_attr_state r_attr, n_attr;
    logic [7:0]           r_saved_row, n_saved_row;
    logic [7:0]           r_saved_col, n_saved_col;
    logic                 r_out_valid;
    aep_pkg::t_result     r_out, n_out;

    logic [MP:0][7:0] a;
    logic [7:0]       n;
    logic [7:0]       p0, p1;
    logic [8:0]       sum_row, sum_col;
    logic             two_args;

    assign o_pop    = !i_empty && (!r_out_valid || i_m_tready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        for (int i = 0; i <= MP; i++) begin
            a[i] = (CW'(i) < i_cmd.argc && i < MP) ? i_cmd.args[i % MP] : 8'd0;
        end
        n       = (a[0] == 8'd0) ? 8'd1 : a[0];
        sum_row = {1'b0, i_cmd.row} + {1'b0, n};
        sum_col = {1'b0, i_cmd.col} + {1'b0, n};

        p0       = a[0];
        p1       = a[1];
        two_args = (i_cmd.argc <= CW'(2));
        if (i_cmd.argc == CW'(1)) begin
            if (i_cmd.lead_semi) begin
                p1 = a[0];
                p0 = 8'd1;
            end else begin
                p1 = 8'd1;
            end
        end
        if (p0 == 8'd0) begin
            p0 = 8'd1;
        end
        if (p1 == 8'd0) begin
            p1 = 8'd1;
        end

        n_attr      = r_attr;
        n_saved_row = r_saved_row;
        n_saved_col = r_saved_col;

        n_out.in_seq  = i_cmd.in_seq;
        n_out.action  = aep_pkg::ACT_NONE;
        n_out.new_row = 8'd0;
        n_out.new_col = 8'd0;

        if (i_cmd.exec) begin
            case (i_cmd.letter)
                aep_pkg::CMD_CLEAR: begin
                    n_out.action = aep_pkg::ACT_CLEAR;
                end
                aep_pkg::CMD_ERASE: begin
                    n_out.action = aep_pkg::ACT_ERASE;
                end
                aep_pkg::CMD_STATUS: begin
                    n_out.action = (a[0] == aep_pkg::DSR_CURSOR) ? aep_pkg::ACT_STATUS
                                                                 : aep_pkg::ACT_NONE;
                end
                aep_pkg::CMD_SGR: begin
                    for (int i = 0; i < MP; i++) begin
                        if (CW'(i) < i_cmd.argc) begin
                            n_attr = aep_pkg::apply_sgr(n_attr, a[i], i_cfg);
                        end
                    end
                end
                aep_pkg::CMD_SAVE: begin
                    n_saved_row = i_cmd.row;
                    n_saved_col = i_cmd.col;
                end
                aep_pkg::CMD_RESTORE: begin
                    n_out.action  = aep_pkg::ACT_MOVE;
                    n_out.new_row = r_saved_row;
                    n_out.new_col = r_saved_col;
                end
                aep_pkg::CMD_UP: begin
                    n_out.action  = aep_pkg::ACT_MOVE;
                    n_out.new_row = (i_cmd.row >= n) ? i_cmd.row - n : i_cmd.row;
                    n_out.new_col = i_cmd.col;
                end
                aep_pkg::CMD_DOWN: begin
                    n_out.action  = aep_pkg::ACT_MOVE;
                    n_out.new_row = (sum_row < {1'b0, i_cfg.scroll_limit}) ? sum_row[7:0]
                                                                           : i_cmd.row;
                    n_out.new_col = i_cmd.col;
                end
                aep_pkg::CMD_LEFT: begin
                    n_out.action  = aep_pkg::ACT_MOVE;
                    n_out.new_row = i_cmd.row;
                    n_out.new_col = (i_cmd.col >= n) ? i_cmd.col - n : i_cmd.col;
                end
                aep_pkg::CMD_RIGHT: begin
                    n_out.action  = aep_pkg::ACT_MOVE;
                    n_out.new_row = i_cmd.row;
                    n_out.new_col = (sum_col < {1'b0, i_cfg.screen_cols}) ? sum_col[7:0]
                                                                          : i_cmd.col;
                end
                aep_pkg::CMD_POS_F, aep_pkg::CMD_POS_H: begin
                    if (i_cmd.argc == '0) begin
                        n_out.action = aep_pkg::ACT_MOVE;
                    end else if (two_args
                                 && {1'b0, p0} < ({1'b0, i_cfg.screen_rows} + 9'd1)
                                 && p1 < i_cfg.screen_cols) begin
                        n_out.action  = aep_pkg::ACT_MOVE;
                        n_out.new_row = p0 - 8'd1;
                        n_out.new_col = p1 - 8'd1;
                    end else begin
                        n_out.action = aep_pkg::ACT_UNKNOWN;
                    end
                end
                default: begin
                    n_out.action = aep_pkg::ACT_UNKNOWN;
                end
            endcase
        end

        n_out.text_attr = n_attr.attr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr.attr  <= aep_pkg::RST_NORMAL_ATTR;
            r_attr.blink <= 1'b0;
            r_attr.bold  <= 1'b0;
            r_saved_row  <= 8'd0;
            r_saved_col  <= 8'd0;
            r_out_valid  <= 1'b0;
        end else if (o_pop) begin
            r_attr      <= n_attr;
            r_saved_row <= n_saved_row;
            r_saved_col <= n_saved_col;
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_pop_fills_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped command left no result");

    a_open_seq_no_action : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.in_seq |-> r_out.action == aep_pkg::ACT_NONE)
        else $error("action reported while sequence open");

endmodule

// ----- tb/sv/tb_ansi_escape_parser_top.sv -----
// ----------------------------------------------------------------------------
// tb_ansi_escape_parser_top
// Self-checking bench for the terminal escape sequence parser. Bytes with a
// cursor position are streamed in, mostly under random idling on both sides. A
// behavioural parser predicts each result, and every returned result is
// checked field by field against the oldest pending prediction. Register
// settings change between phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_ansi_escape_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aep_pkg::*;

    localparam logic [7:0] CHR_NINE    = CHR_ZERO + 8'd9;
    localparam logic [7:0] CHR_UPPER_A = "A";
    localparam logic [7:0] CHR_LOWER_A = "a";
    localparam int         IDLE_PCT    = 37;

    localparam logic [2:0] COLOUR_REMAP [8] = '{3'h0, 3'h4, 3'h2, 3'h6,
                                                 3'h1, 3'h5, 3'h3, 3'h7};
    localparam logic [7:0] COMMAND_LETTERS [12] = '{CMD_CLEAR, CMD_ERASE, CMD_STATUS,
                                                    CMD_SGR, CMD_SAVE, CMD_RESTORE,
                                                    CMD_UP, CMD_DOWN, CMD_RIGHT,
                                                    CMD_LEFT, CMD_POS_F, CMD_POS_H};
    localparam logic [7:0] SGR_CODES [5] = '{SGR_NORMAL, SGR_BOLD, SGR_UNDERLINE,
                                             SGR_BLINK, SGR_REVERSE};
    localparam logic [REG_IDX_W-1:0] REG_ORDER [NUM_REGS] = '{REG_NORMAL_ATTR,
                                                              REG_REVERSE_ATTR,
                                                              REG_BOLD_ATTR,
                                                              REG_SCREEN_ROWS,
                                                              REG_SCREEN_COLS,
                                                              REG_SCROLL_LIMIT};

    logic               i_clk;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [IN_W-1:0]    i_s_tdata  = '0;  // char_in, cur_row, cur_col
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [OUT_W-1:0]   o_m_tdata;        // in_sequence, action, new_row, new_col,
                                          // text_attr, zero pad
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [PADDR_W-1:0] paddr      = '0;
    logic [31:0]        pwdata     = '0;
    logic [31:0]        prdata;
    logic               pready;

    t_result    expected_results [$];
    int         bytes_sent      = 0;
    int         results_checked = 0;
    int         mismatches      = 0;
    int         settings_loaded = 0;
    bit         no_idle         = 1'b0;

    // parser state as predicted
    t_cfg       cfg_model;
    logic       esc_seen;
    logic [7:0] arg_val [MAX_PARAMS];
    int         arg_cnt;
    logic       in_number;
    logic       body_empty;
    logic       semi_first;
    logic [7:0] attr_now;
    logic       blink_now;
    logic       bold_now;
    logic [7:0] mark_row;
    logic [7:0] mark_col;

    ansi_escape_parser_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_args();
        foreach (arg_val[i]) arg_val[i] = 8'd0;
        arg_cnt    = 0;
        in_number  = 1'b0;
        body_empty = 1'b1;
        semi_first = 1'b0;
    endfunction

    function automatic void reset_model();
        cfg_model = '{RST_NORMAL_ATTR, RST_REVERSE_ATTR, RST_BOLD_ATTR,
                      RST_SCREEN_ROWS, RST_SCREEN_COLS, RST_SCROLL_LIMIT};
        esc_seen  = 1'b0;
        clear_args();
        attr_now  = RST_NORMAL_ATTR;
        blink_now = 1'b0;
        bold_now  = 1'b0;
        mark_row  = 8'd0;
        mark_col  = 8'd0;
    endfunction

    function automatic bit is_letter(input logic [7:0] ch);
        return (ch >= CHR_UPPER_A && ch <= CHR_UPPER_A + 8'd25) ||
               (ch >= CHR_LOWER_A && ch <= CHR_LOWER_A + 8'd25);
    endfunction

    function automatic void apply_attr(input logic [7:0] v);
        if (v == SGR_BLINK) begin
            attr_now  = attr_now | 8'h80;
            blink_now = 1'b1;
        end else if (v == SGR_UNDERLINE) begin
            attr_now = attr_now | 8'h01;
        end else if (v == SGR_REVERSE) begin
            attr_now = cfg_model.reverse_attr;
        end else if (v == SGR_NORMAL) begin
            attr_now  = cfg_model.normal_attr;
            blink_now = 1'b0;
            bold_now  = 1'b0;
        end else if (v == SGR_BOLD) begin
            attr_now = cfg_model.bold_attr;
            bold_now = 1'b1;
        end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
            attr_now = (attr_now & 8'h0F) | (8'(COLOUR_REMAP[v - SGR_BG_LO]) << 4)
                       | (blink_now ? 8'h80 : 8'h00);
        end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
            attr_now = (attr_now & 8'hF0) | 8'(COLOUR_REMAP[v - SGR_FG_LO])
                       | (bold_now ? 8'h08 : 8'h00);
        end
    endfunction

    function automatic t_result parse_byte(input logic [7:0] ch, input logic [7:0] row,
                                           input logic [7:0] col);
        t_result    r;
        int         argc, n, a0, a1, digit, acc, i;
        logic [7:0] a [MAX_PARAMS];
        r = '0;
        r.action = ACT_NONE;
        if (ch == ESC_BYTE) begin
            clear_args();
            esc_seen = 1'b1;
            r.in_seq = 1'b1;
        end else if (esc_seen) begin
            esc_seen = 1'b0;
            r.in_seq = (ch == CHR_LBRACKET);
        end else if (!is_letter(ch)) begin
            if (ch >= CHR_ZERO && ch <= CHR_NINE) begin
                digit = ch - CHR_ZERO;
                if (in_number) begin
                    if (arg_cnt >= 1 && arg_cnt <= MAX_PARAMS) begin
                        acc = arg_val[arg_cnt-1] * 10 + digit;
                        arg_val[arg_cnt-1] = (acc > SAT_LIMIT) ? SAT_LIMIT : 8'(acc);
                    end
                end else begin
                    if (arg_cnt <= MAX_PARAMS) begin
                        arg_cnt++;
                        if (arg_cnt <= MAX_PARAMS) arg_val[arg_cnt-1] = 8'(digit);
                    end
                    in_number = 1'b1;
                end
            end else begin
                if (body_empty && ch == CHR_SEMI) semi_first = 1'b1;
                in_number = 1'b0;
            end
            body_empty = 1'b0;
            r.in_seq   = 1'b1;
        end else begin
            argc = (arg_cnt > MAX_PARAMS) ? MAX_PARAMS : arg_cnt;
            for (i = 0; i < MAX_PARAMS; i++) a[i] = (i < argc) ? arg_val[i] : 8'd0;
            n = (argc != 0) ? a[0] : 1;
            if (n == 0) n = 1;
            case (ch)
                CMD_CLEAR: r.action = ACT_CLEAR;
                CMD_ERASE: r.action = ACT_ERASE;
                CMD_STATUS: r.action = (a[0] == DSR_CURSOR) ? ACT_STATUS : ACT_NONE;
                CMD_SGR: begin
                    for (i = 0; i < argc; i++) apply_attr(a[i]);
                end
                CMD_SAVE: begin
                    mark_row = row;
                    mark_col = col;
                end
                CMD_RESTORE: begin
                    r.action  = ACT_MOVE;
                    r.new_row = mark_row;
                    r.new_col = mark_col;
                end
                CMD_UP, CMD_DOWN, CMD_LEFT, CMD_RIGHT: begin
                    r.action  = ACT_MOVE;
                    r.new_row = row;
                    r.new_col = col;
                    if (ch == CMD_UP && row >= n) r.new_row = 8'(row - n);
                    if (ch == CMD_DOWN && row + n < cfg_model.scroll_limit)
                        r.new_row = 8'(row + n);
                    if (ch == CMD_LEFT && col >= n) r.new_col = 8'(col - n);
                    if (ch == CMD_RIGHT && col + n < cfg_model.screen_cols)
                        r.new_col = 8'(col + n);
                end
                CMD_POS_F, CMD_POS_H: begin
                    if (argc == 0) begin
                        r.action = ACT_MOVE;
                    end else begin
                        a0 = a[0];
                        a1 = (argc >= 2) ? a[1] : 0;
                        if (argc == 1) begin
                            if (semi_first) begin
                                a1 = a0;
                                a0 = 1;
                            end else begin
                                a1 = 1;
                            end
                            argc = 2;
                        end
                        if (a0 == 0) a0 = 1;
                        if (a1 == 0) a1 = 1;
                        if (argc == 2 && a0 < cfg_model.screen_rows + 1 &&
                            a1 < cfg_model.screen_cols) begin
                            r.action  = ACT_MOVE;
                            r.new_row = 8'(a0 - 1);
                            r.new_col = 8'(a1 - 1);
                        end else begin
                            r.action = ACT_UNKNOWN;
                        end
                    end
                end
                default: r.action = ACT_UNKNOWN;
            endcase
            clear_args();
            r.in_seq = 1'b0;
        end
        r.text_attr = attr_now;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $error("result with none expected: tdata %h", o_m_tdata);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                check_field("in_sequence", 8'(want.in_seq), 8'(o_m_tdata[0]));
                check_field("action", 8'(want.action), 8'(o_m_tdata[3:1]));
                check_field("new_row", want.new_row, o_m_tdata[11:4]);
                check_field("new_col", want.new_col, o_m_tdata[19:12]);
                check_field("text_attr", want.text_attr, o_m_tdata[27:20]);
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_byte(input logic [7:0] ch, input logic [7:0] row,
                             input logic [7:0] col);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {col, row, ch};
        do @(posedge i_clk); while (!o_s_tready);
        expected_results.push_back(parse_byte(ch, row, col));
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic [7:0] row, input logic [7:0] col);
        int k;
        for (k = 0; k < s.len(); k++) send_byte(s[k], row, col);
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic load_config(input t_cfg c);
        logic [7:0] vals [NUM_REGS];
        int         i;
        vals = '{c.normal_attr, c.reverse_attr, c.bold_attr,
                 c.screen_rows, c.screen_cols, c.scroll_limit};
        wait_for_results();
        for (i = 0; i < NUM_REGS; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {REG_ORDER[i], 2'b00};
            pwdata  <= 32'(vals[i]);
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_model = c;
        settings_loaded++;
    endtask

    function automatic logic [7:0] pick_coord();
        return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(90));
    endfunction

    function automatic logic [7:0] noise_byte();
        return $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
    endfunction

    function automatic int param_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return $urandom_range(9);
        if (pick < 45) return SGR_CODES[$urandom_range(4)];
        if (pick < 60) return $urandom_range(1) ? $urandom_range(30, 37) : $urandom_range(40, 47);
        if (pick < 85) return $urandom_range(10, 99);
        if (pick < 95) return $urandom_range(100, 999);
        return $urandom_range(1000, 99999);
    endfunction

    // mostly well-formed sequences, some noise, broken prefixes and restarts
    task automatic send_random_sequence();
        int         kind, nparm, i;
        logic [7:0] row, col, fin;
        kind = $urandom_range(99);
        row  = pick_coord();
        col  = pick_coord();
        if (kind < 15) begin
            repeat ($urandom_range(1, 4)) send_byte(noise_byte(), row, col);
        end else begin
            send_byte(ESC_BYTE, row, col);
            if (kind < 22) begin
                send_byte(noise_byte(), row, col);
            end else begin
                if (kind < 27) begin
                    send_byte(CHR_LBRACKET, row, col);
                    send_text($sformatf("%0d", param_value()), row, col);
                    send_byte(ESC_BYTE, row, col);
                end
                send_byte(CHR_LBRACKET, row, col);
                if ($urandom_range(7) == 0) send_byte(CHR_SEMI, row, col);
                nparm = ($urandom_range(3) == 0) ? $urandom_range(3, 7) : $urandom_range(2);
                for (i = 0; i < nparm; i++) begin
                    if (i != 0)
                        send_byte(($urandom_range(9) == 0) ? 8'($urandom_range(32, 47))
                                                           : CHR_SEMI, row, col);
                    send_text($sformatf("%0d", param_value()), row, col);
                end
                if ($urandom_range(4) == 0)
                    fin = 8'($urandom_range(25)) +
                          ($urandom_range(1) ? CHR_LOWER_A : CHR_UPPER_A);
                else
                    fin = COMMAND_LETTERS[$urandom_range(11)];
                send_byte(fin, row, col);
            end
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            send_random_sequence();
            if ($urandom_range(39) == 0) wait_for_results();
        end
    endtask

    task automatic test_plain_commands();
        send_text("J", 8'd0, 8'd0);
        send_text("K", 8'd255, 8'd255);
        send_text("6n", 8'd7, 8'd7);
        send_text("q", 8'd1, 8'd1);
    endtask

    task automatic test_escape_handling();
        send_byte(ESC_BYTE, 8'd0, 8'd0);
        send_text("x", 8'd0, 8'd0);
        send_text("A", 8'd0, 8'd255);
        send_byte(ESC_BYTE, 8'd3, 8'd10);
        send_text("[9", 8'd3, 8'd10);
        send_byte(ESC_BYTE, 8'd3, 8'd10);
        send_text("[C", 8'd3, 8'd10);
    endtask

    task automatic test_parameters();
        send_text(";7H", 8'd3, 8'd3);
        send_text("999B", 8'd20, 8'd0);
        send_text("0D", 8'd5, 8'd5);
    endtask

    task automatic test_attributes();
        send_text("m", 8'd0, 8'd0);
        send_text("5;1;34;44;4;0m", 8'd0, 8'd0);
    endtask

    task automatic test_cursor_memory();
        send_text("s", 8'd12, 8'd34);
        send_text("u", 8'd0, 8'd0);
        send_text("f", 8'd9, 8'd9);
    endtask

    task automatic test_random_reset_config();
        run_random(150);
    endtask

    task automatic test_random_minimum_config();
        t_cfg c;
        c = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0};
        load_config(c);
        run_random(100);
    endtask

    task automatic test_random_maximum_config();
        t_cfg c;
        c = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
        load_config(c);
        no_idle = 1'b1;
        run_random(100);
        no_idle = 1'b0;
    endtask

    task automatic test_random_mixed_config();
        t_cfg c;
        repeat (4) begin
            c.normal_attr  = 8'($urandom_range(255));
            c.reverse_attr = 8'($urandom_range(255));
            c.bold_attr    = 8'($urandom_range(255));
            c.screen_rows  = 8'($urandom_range(255));
            c.screen_cols  = 8'($urandom_range(1, 255));
            c.scroll_limit = 8'($urandom_range(255));
            load_config(c);
            run_random(60);
        end
    endtask

    initial begin
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_commands();
        test_escape_handling();
        test_parameters();
        test_attributes();
        test_cursor_memory();
        test_random_reset_config();
        test_random_minimum_config();
        test_random_maximum_config();
        test_random_mixed_config();
        wait_for_results();
        repeat (8) @(posedge i_clk);
        $display("covered %0d bytes and %0d checked results over %0d register settings",
                 bytes_sent, results_checked, settings_loaded + 1);
        $display("sequences, noise, restarts and all commands under random idling");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/aep_pkg.sv
rtl/aep_cfg.sv
rtl/aep_front.sv
rtl/aep_fifo.sv
rtl/aep_back.sv
rtl/ansi_escape_parser_top.sv
tb/sv/tb_ansi_escape_parser_top.sv
